FILE: src/homogeneous_point_transform_4x4_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the homogeneous point transform core
// Shared concurrent assertion forms, clocked on i_clk.
// ----------------------------------------------------------------------------
`ifndef HOMOGENEOUS_POINT_TRANSFORM_4X4_CORE_MACROS_SVH
`define HOMOGENEOUS_POINT_TRANSFORM_4X4_CORE_MACROS_SVH

// Check a property outside of reset.
`define HPT4_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check a property at every edge, reset included.
`define HPT4_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: src/hpt4_pkg.sv
// ----------------------------------------------------------------------------
// hpt4_pkg
// Widths, register codes and payload types of the point transform core.
// ----------------------------------------------------------------------------
`default_nettype none

package hpt4_pkg;

    localparam int NCOMP      = 4;
    localparam int COEF_W     = 16;
    localparam int ROW_W      = NCOMP * COEF_W;
    localparam int PT_W       = 32;
    localparam int FRAC       = 12;
    localparam int PROD_W     = COEF_W + PT_W;
    localparam int PAIR_W     = PROD_W + 1;
    localparam int SUM_W      = PROD_W + 2;
    localparam int SH_W       = SUM_W - FRAC;
    localparam int CFG_ADDR_W = 3;

    localparam logic [CFG_ADDR_W-1:0] REG_ROW0 = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_ROW1 = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_ROW2 = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_ROW3 = 3'd3;

    // identity matrix, 1.0 in Q4.12 on the diagonal
    localparam logic [ROW_W-1:0] ROW0_RESET = 64'h0000_0000_0000_1000;
    localparam logic [ROW_W-1:0] ROW1_RESET = 64'h0000_0000_1000_0000;
    localparam logic [ROW_W-1:0] ROW2_RESET = 64'h0000_1000_0000_0000;
    localparam logic [ROW_W-1:0] ROW3_RESET = 64'h1000_0000_0000_0000;

    localparam logic [PT_W-1:0] PT_MAX = 32'h7FFF_FFFF;
    localparam logic [PT_W-1:0] PT_MIN = 32'h8000_0000;

    typedef logic [NCOMP-1:0][ROW_W-1:0]            t_matrix;
    typedef logic [NCOMP-1:0][PT_W-1:0]             t_point;
    typedef logic [NCOMP-1:0][NCOMP-1:0][PROD_W-1:0] t_prods;
    typedef logic [NCOMP-1:0][SUM_W-1:0]            t_sums;

endpackage

`default_nettype wire

FILE: src/homogeneous_point_transform_4x4_core.sv
// An accepted input beat passes through the product, pair-sum, row-total and
// clip/output registers in that order before o_valid rises with its result.
// Throughput: one point per cycle; four register stages (products, pair sums,
// row totals, clip/output) advance together unless the output side stalls.
// Reset (synchronous, active low) empties the pipeline and loads the
// identity matrix into the four row registers.
// ----------------------------------------------------------------------------
// homogeneous_point_transform_4x4_core
// Multiplies a stream of Q16.16 homogeneous points by a Q4.12 4x4 matrix.
// ----------------------------------------------------------------------------
`default_nettype none

module homogeneous_point_transform_4x4_core
    import hpt4_pkg::*;
#(
    parameter int DIM = 4
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_ADDR_W-1:0]  i_cfg_addr,
    input  wire logic [ROW_W-1:0]       i_cfg_data,
    input  wire logic                   i_valid,
    output logic                        o_stall,
    input  wire logic signed [PT_W-1:0] i_in_x,
    input  wire logic signed [PT_W-1:0] i_in_y,
    input  wire logic signed [PT_W-1:0] i_in_z,
    input  wire logic signed [PT_W-1:0] i_in_w,
    output logic                        o_valid,
    input  wire logic                   i_stall,
    output logic signed [PT_W-1:0]      o_out_x,
    output logic signed [PT_W-1:0]      o_out_y,
    output logic signed [PT_W-1:0]      o_out_z,
    output logic signed [PT_W-1:0]      o_out_w,
    output logic                        o_saturated
);

    t_matrix r_rows;
    t_point  w_in_point;
    t_point  w_out_point;
    t_prods  w_prods;
    t_sums   w_sums;
    logic    w_in_ready;
    logic    w_mul_valid;
    logic    w_acc_ready;
    logic    w_acc_valid;
    logic    w_sat_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows[0] <= ROW0_RESET;
            r_rows[1] <= ROW1_RESET;
            r_rows[2] <= ROW2_RESET;
            r_rows[3] <= ROW3_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_ROW0: r_rows[0] <= i_cfg_data;
                REG_ROW1: r_rows[1] <= i_cfg_data;
                REG_ROW2: r_rows[2] <= i_cfg_data;
                REG_ROW3: r_rows[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_in_point[0] = i_in_x;
    assign w_in_point[1] = i_in_y;
    assign w_in_point[2] = i_in_z;
    assign w_in_point[3] = i_in_w;

    hpt4_mul_stage #(
        .DIM (DIM)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rows  (r_rows),
        .i_point (w_in_point),
        .i_valid (i_valid),
        .o_ready (w_in_ready),
        .o_valid (w_mul_valid),
        .i_ready (w_acc_ready),
        .o_prods (w_prods)
    );

    hpt4_acc_stage u_acc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_prods (w_prods),
        .i_valid (w_mul_valid),
        .o_ready (w_acc_ready),
        .o_valid (w_acc_valid),
        .i_ready (w_sat_ready),
        .o_sums  (w_sums)
    );

    hpt4_sat_stage u_sat (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sums      (w_sums),
        .i_valid     (w_acc_valid),
        .o_ready     (w_sat_ready),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_point     (w_out_point),
        .o_saturated (o_saturated)
    );

    assign o_stall = !w_in_ready;
    assign o_out_x = w_out_point[0];
    assign o_out_y = w_out_point[1];
    assign o_out_z = w_out_point[2];
    assign o_out_w = w_out_point[3];

endmodule

`default_nettype wire

FILE: src/hpt4_mul_stage.sv
// ----------------------------------------------------------------------------
// hpt4_mul_stage
// First pipeline stage: all coefficient-by-component products within DIM, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module hpt4_mul_stage
    import hpt4_pkg::*;
#(
    parameter int DIM = 4
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_matrix i_rows,
    input  wire t_point  i_point,
    input  wire logic    i_valid,
    output logic         o_ready,
    output logic         o_valid,
    input  wire logic    i_ready,
    output t_prods       o_prods
);

    t_prods n_prods;
    t_prods r_prods;
    logic   r_valid;

    for (genvar gi = 0; gi < NCOMP; gi++) begin : g_row
        for (genvar gj = 0; gj < NCOMP; gj++) begin : g_col
            if (gi < DIM && gj < DIM) begin : g_mul
                logic signed [COEF_W-1:0] w_coef;
                logic signed [PT_W-1:0]   w_pt;
                logic signed [PROD_W-1:0] w_prod;
                assign w_coef = i_rows[gi][gj*COEF_W +: COEF_W];
                assign w_pt   = i_point[gj];
                assign w_prod = w_coef * w_pt;
                assign n_prods[gi][gj] = w_prod;
            end else begin : g_zero
                assign n_prods[gi][gj] = '0;
            end
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_prods <= n_prods;
        end
    end

    assign o_valid = r_valid;
    assign o_prods = r_prods;

endmodule

`default_nettype wire

FILE: src/hpt4_acc_stage.sv
// ----------------------------------------------------------------------------
// hpt4_acc_stage
// Two registered adder levels: pairwise sums, then the row totals.
// ----------------------------------------------------------------------------
`default_nettype none

module hpt4_acc_stage
    import hpt4_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_prods i_prods,
    input  wire logic   i_valid,
    output logic        o_ready,
    output logic        o_valid,
    input  wire logic   i_ready,
    output t_sums       o_sums
);

    logic [NCOMP-1:0][1:0][PAIR_W-1:0] n_pair;
    logic [NCOMP-1:0][1:0][PAIR_W-1:0] r_pair;
    t_sums                             n_sum;
    t_sums                             r_sum;
    logic                              r_pair_valid;
    logic                              r_sum_valid;
    logic                              w_sum_ready;

    always_comb begin
        for (int i = 0; i < NCOMP; i++) begin
            for (int k = 0; k < 2; k++) begin
                n_pair[i][k] = PAIR_W'($signed(i_prods[i][2*k]))
                             + PAIR_W'($signed(i_prods[i][2*k+1]));
            end
            n_sum[i] = SUM_W'($signed(r_pair[i][0])) + SUM_W'($signed(r_pair[i][1]));
        end
    end

    assign w_sum_ready = !r_sum_valid || i_ready;
    assign o_ready     = !r_pair_valid || w_sum_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pair_valid <= 1'b0;
            r_sum_valid  <= 1'b0;
        end else begin
            if (o_ready) begin
                r_pair_valid <= i_valid;
            end
            if (w_sum_ready) begin
                r_sum_valid <= r_pair_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_pair <= n_pair;
        end
        if (w_sum_ready && r_pair_valid) begin
            r_sum <= n_sum;
        end
    end

    assign o_valid = r_sum_valid;
    assign o_sums  = r_sum;

endmodule

`default_nettype wire

FILE: src/hpt4_sat_stage.sv
// ----------------------------------------------------------------------------
// hpt4_sat_stage
// Drop the fraction bits, clip each total to 32 bits, hold the result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module hpt4_sat_stage
    import hpt4_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_sums i_sums,
    input  wire logic  i_valid,
    output logic       o_ready,
    output logic       o_valid,
    input  wire logic  i_stall,
    output t_point     o_point,
    output logic       o_saturated
);

    t_point           n_point;
    logic             n_sat;
    t_point           r_point;
    logic             r_sat;
    logic             r_valid;
    logic [SH_W-1:0]  w_sh [NCOMP];
    logic [NCOMP-1:0] w_over;
    logic [NCOMP-1:0] w_under;

    always_comb begin
        for (int i = 0; i < NCOMP; i++) begin
            // arithmetic shift is just the upper bits of the total
            w_sh[i]    = i_sums[i][SUM_W-1:FRAC];
            w_over[i]  = !w_sh[i][SH_W-1] && (|w_sh[i][SH_W-2:PT_W-1]);
            w_under[i] = w_sh[i][SH_W-1] && !(&w_sh[i][SH_W-2:PT_W-1]);
            if (w_over[i]) begin
                n_point[i] = PT_MAX;
            end else if (w_under[i]) begin
                n_point[i] = PT_MIN;
            end else begin
                n_point[i] = w_sh[i][PT_W-1:0];
            end
        end
        n_sat = |(w_over | w_under);
    end

    assign o_ready = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_point <= n_point;
            r_sat   <= n_sat;
        end
    end

    assign o_valid     = r_valid;
    assign o_point     = r_point;
    assign o_saturated = r_sat;

endmodule

`default_nettype wire

FILE: src/hpt4_checker.sv
// ----------------------------------------------------------------------------
// hpt4_checker
// Port-level checks of the point transform core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "homogeneous_point_transform_4x4_core_macros.svh"

module hpt4_checker
    import hpt4_pkg::*;
(
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   i_valid,
    input wire logic                   o_stall,
    input wire logic                   o_valid,
    input wire logic                   i_stall,
    input wire logic signed [PT_W-1:0] o_out_x,
    input wire logic signed [PT_W-1:0] o_out_y,
    input wire logic signed [PT_W-1:0] o_out_z,
    input wire logic signed [PT_W-1:0] o_out_w,
    input wire logic                   o_saturated
);

    // a held result beat keeps its payload
    `HPT4_ASSERT(a_out_hold, o_valid && i_stall |=> o_valid && $stable(o_out_x) && $stable(o_out_y) && $stable(o_out_z) && $stable(o_out_w) && $stable(o_saturated), "result beat changed while stalled")

    // reset empties the pipeline
    `HPT4_ASSERT_ALWAYS(a_rst_empty, !i_rst_n |=> !o_valid, "result valid right after reset")

    // an accepted beat reaches the output if the receiver does not stall meanwhile
    `HPT4_ASSERT(a_latency, (i_valid && !o_stall) ##1 !i_stall ##1 !i_stall ##1 !i_stall |=> o_valid, "accepted beat did not reach the output in time")

endmodule

bind homogeneous_point_transform_4x4_core hpt4_checker u_hpt4_checker (.*);

`default_nettype wire

FILE: test/tb_homogeneous_point_transform_4x4_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_homogeneous_point_transform_4x4_core
// Streams Q16.16 points through the 4x4 transform core and checks every
// result beat against a behavioral transform with saturation and floor
// rounding. Matrices are reloaded between bursts, under several idle and
// stall mixes, plus one long output hold-off that backs the pipeline up.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_homogeneous_point_transform_4x4_core
    import hpt4_pkg::*;
();

    localparam int     DIM        = 4;
    localparam int     DRAIN_WAIT = 10;
    localparam longint SUM_HI     = 64'sh0000_0000_7FFF_FFFF;
    localparam longint SUM_LO     = -64'sh0000_0000_8000_0000;

    // register indexes outside the matrix, writes there must be dropped
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_LO = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_HI = 3'd7;

    typedef struct {
        logic signed [PT_W-1:0] x;
        logic signed [PT_W-1:0] y;
        logic signed [PT_W-1:0] z;
        logic signed [PT_W-1:0] w;
        logic                   sat;
    } t_point_result;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_ADDR_W-1:0]  i_cfg_addr;
    logic [ROW_W-1:0]       i_cfg_data;
    logic                   i_valid;
    logic                   o_stall;
    logic signed [PT_W-1:0] i_in_x;
    logic signed [PT_W-1:0] i_in_y;
    logic signed [PT_W-1:0] i_in_z;
    logic signed [PT_W-1:0] i_in_w;
    logic                   o_valid;
    logic                   i_stall;
    logic signed [PT_W-1:0] o_out_x;
    logic signed [PT_W-1:0] o_out_y;
    logic signed [PT_W-1:0] o_out_z;
    logic signed [PT_W-1:0] o_out_w;
    logic                   o_saturated;

    t_matrix       matrix_rows;
    t_point_result expected_points[$];
    int            error_count;
    int            tx_idle_pct;
    int            rx_stall_pct;
    int            stall_hold;

    homogeneous_point_transform_4x4_core #(
        .DIM(DIM)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_in_x     (i_in_x),
        .i_in_y     (i_in_y),
        .i_in_z     (i_in_z),
        .i_in_w     (i_in_w),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_out_x    (o_out_x),
        .o_out_y    (o_out_y),
        .o_out_z    (o_out_z),
        .o_out_w    (o_out_w),
        .o_saturated(o_saturated)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Sum of coefficient-by-component products, floored by 2^FRAC, clipped.
    function automatic t_point_result transform_point(t_point pt);
        t_point_result          res;
        t_point                 comps;
        logic signed [COEF_W-1:0] coef;
        logic signed [PT_W-1:0] comp;
        longint                 acc;
        longint                 shifted;
        res.sat = 1'b0;
        comps   = '0;
        for (int i = 0; i < DIM; i++) begin
            acc = 0;
            for (int j = 0; j < DIM; j++) begin
                coef = matrix_rows[i][COEF_W*j +: COEF_W];
                comp = pt[j];
                acc += longint'(coef) * longint'(comp);
            end
            shifted = acc >>> FRAC;
            if (shifted > SUM_HI) begin
                comps[i] = PT_MAX;
                res.sat  = 1'b1;
            end else if (shifted < SUM_LO) begin
                comps[i] = PT_MIN;
                res.sat  = 1'b1;
            end else begin
                comps[i] = shifted[PT_W-1:0];
            end
        end
        res.x = comps[0];
        res.y = comps[1];
        res.z = comps[2];
        res.w = comps[3];
        return res;
    endfunction

    function automatic logic [PT_W-1:0] rand_component();
        logic [PT_W-1:0] v;
        case ($urandom_range(0, 7))
            0, 1, 2: v = $urandom;
            3, 4:    v = $urandom_range(0, 32'h0003_FFFF) - 32'h0002_0000;
            5:       v = $urandom_range(0, 1) ? PT_MAX : PT_MIN;
            6:       v = $signed($urandom) >>> $urandom_range(4, 20);
            default: v = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
        endcase
        return v;
    endfunction

    function automatic t_point rand_point();
        t_point pt;
        for (int j = 0; j < NCOMP; j++) begin
            pt[j] = rand_component();
        end
        return pt;
    endfunction

    function automatic logic [ROW_W-1:0] rand_row();
        logic [ROW_W-1:0]  row;
        logic [COEF_W-1:0] c;
        for (int j = 0; j < NCOMP; j++) begin
            case ($urandom_range(0, 5))
                0, 1:    c = 16'($urandom_range(0, 16'hFFFF));
                2, 3:    c = 16'($urandom_range(0, 16'h2000) - 16'h1000);
                4:       c = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
                default: begin
                    case ($urandom_range(0, 2))
                        0:       c = 16'h0000;
                        1:       c = 16'h1000;
                        default: c = 16'hF000;
                    endcase
                end
            endcase
            row[COEF_W*j +: COEF_W] = c;
        end
        return row;
    endfunction

    // Drop valid and let the pipeline empty out before touching registers.
    task automatic wait_drained();
        i_valid = 1'b0;
        while (expected_points.size() != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    task automatic write_row(input logic [CFG_ADDR_W-1:0] idx,
                             input logic [ROW_W-1:0] data);
        wait_drained();
        i_cfg_we   = 1'b1;
        i_cfg_addr = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (idx <= REG_ROW3) matrix_rows[idx] = data;
    endtask

    task automatic load_matrix(input logic [ROW_W-1:0] r0, input logic [ROW_W-1:0] r1,
                               input logic [ROW_W-1:0] r2, input logic [ROW_W-1:0] r3);
        write_row(REG_ROW0, r0);
        write_row(REG_ROW1, r1);
        write_row(REG_ROW2, r2);
        write_row(REG_ROW3, r3);
    endtask

    // Entered and left just after a falling edge; valid stays high on exit.
    task automatic send_point(input t_point pt);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_in_x  = pt[0];
        i_in_y  = pt[1];
        i_in_z  = pt[2];
        i_in_w  = pt[3];
        do @(posedge i_clk); while (o_stall);
        expected_points.push_back(transform_point(pt));
        @(negedge i_clk);
    endtask

    task automatic send_xyzw(input logic [PT_W-1:0] x, input logic [PT_W-1:0] y,
                             input logic [PT_W-1:0] z, input logic [PT_W-1:0] w);
        t_point pt;
        pt[0] = x;
        pt[1] = y;
        pt[2] = z;
        pt[3] = w;
        send_point(pt);
    endtask

    // Receiver stall, with an optional hold-off counted down here.
    always @(negedge i_clk) begin
        if (stall_hold > 0) begin
            i_stall    = 1'b1;
            stall_hold = stall_hold - 1;
        end else begin
            i_stall = ($urandom_range(0, 99) < rx_stall_pct);
        end
    end

    function automatic void check_field(input string name, input logic [PT_W-1:0] exp_v,
                                        input logic [PT_W-1:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0d, got %0d", name, $signed(exp_v), $signed(act_v));
            error_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_point_result exp_pt;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_points.size() == 0) begin
                $error("result beat with nothing expected: x %0d y %0d z %0d w %0d",
                       o_out_x, o_out_y, o_out_z, o_out_w);
                error_count++;
            end else begin
                exp_pt = expected_points.pop_front();
                check_field("out_x", exp_pt.x, o_out_x);
                check_field("out_y", exp_pt.y, o_out_y);
                check_field("out_z", exp_pt.z, o_out_z);
                check_field("out_w", exp_pt.w, o_out_w);
                if (exp_pt.sat !== o_saturated) begin
                    $error("saturated: expected %0b, got %0b", exp_pt.sat, o_saturated);
                    error_count++;
                end
            end
        end
    end

    task automatic test_reset_identity();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        send_xyzw(PT_MAX, PT_MIN, 32'h0000_0000, 32'hFFFF_FFFF);
        send_xyzw(PT_MIN, PT_MAX, 32'h0000_0001, 32'h0001_0000);
        send_xyzw(32'h5555_5555, 32'hAAAA_AAAA, 32'h8000_0001, 32'h7FFF_FFFE);
    endtask

    task automatic test_extreme_coefs();
        load_matrix({4{16'h7FFF}}, {4{16'h7FFF}}, {4{16'h7FFF}}, {4{16'h7FFF}});
        send_xyzw(PT_MAX, PT_MAX, PT_MAX, PT_MAX);
        send_xyzw(PT_MIN, PT_MIN, PT_MIN, PT_MIN);
        send_xyzw(32'h0, 32'h0, 32'h0, 32'h0);
        load_matrix({4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}});
        send_xyzw(PT_MIN, PT_MIN, PT_MIN, PT_MIN);
        send_xyzw(PT_MAX, PT_MAX, PT_MAX, PT_MAX);
        load_matrix({4{16'hFFFF}}, '0, {4{16'h0001}}, {16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000});
        send_xyzw(PT_MAX, PT_MIN, 32'hFFFF_FFFF, 32'h0000_0001);
    endtask

    task automatic test_floor_rounding();
        // one LSB coefficients: tiny negative sums must floor to -1
        load_matrix(64'h0000_0000_0000_0001, 64'h0000_0000_FFFF_0000,
                    64'h0000_0001_0000_0000, 64'h0001_0000_0000_0000);
        send_xyzw(32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0FFF, 32'h0000_1000);
        send_xyzw(32'h0000_0001, 32'hFFFF_FFFF, 32'hFFFF_F001, 32'hFFFF_EFFF);
    endtask

    task automatic test_clip_boundary();
        // 2.0 on the diagonal: land just inside the upper bound and exactly on the lower one, and just past each
        load_matrix(64'h0000_0000_0000_2000, 64'h0000_0000_2000_0000,
                    64'h0000_2000_0000_0000, 64'h2000_0000_0000_0000);
        send_xyzw(32'h4000_0000, 32'h3FFF_FFFF, 32'hC000_0000, 32'hBFFF_FFFF);
        send_xyzw(32'h3FFF_FFFF, 32'h3FFF_FFFF, 32'hC000_0000, 32'hC000_0000);
    endtask

    task automatic test_spare_index();
        write_row(REG_SPARE_LO, '1);
        write_row(REG_SPARE_HI, 64'h8000_7FFF_8000_7FFF);
        send_xyzw(32'h3FFF_FFFF, 32'hC000_0000, 32'h0001_0000, 32'hFFFF_0000);
    endtask

    task automatic test_random_stream(input int n_points, input int tx_pct, input int rx_pct);
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        for (int k = 0; k < n_points; k++) begin
            if (k % 105 == 0) begin
                load_matrix(rand_row(), rand_row(), rand_row(), rand_row());
                if ($urandom_range(0, 3) == 0) begin
                    write_row(3'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)), {$urandom, $urandom});
                end
            end
            send_point(rand_point());
        end
    endtask

    task automatic test_output_holdoff();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        load_matrix(rand_row(), rand_row(), rand_row(), rand_row());
        @(posedge i_clk);
        stall_hold = 200;
        @(negedge i_clk);
        // keep offering while the output is held, so the input stalls
        for (int k = 0; k < 40; k++) begin
            send_point(rand_point());
        end
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_addr   = REG_ROW0;
        i_cfg_data   = '0;
        i_valid      = 1'b0;
        i_in_x       = '0;
        i_in_y       = '0;
        i_in_z       = '0;
        i_in_w       = '0;
        i_stall      = 1'b0;
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        stall_hold   = 0;
        error_count  = 0;
        matrix_rows[0] = ROW0_RESET;
        matrix_rows[1] = ROW1_RESET;
        matrix_rows[2] = ROW2_RESET;
        matrix_rows[3] = ROW3_RESET;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_reset_identity();
        test_extreme_coefs();
        test_floor_rounding();
        test_clip_boundary();
        test_spare_index();
        test_random_stream(420, 0, 0);
        test_random_stream(420, 82, 0);
        test_random_stream(420, 0, 82);
        test_random_stream(420, 9, 9);
        test_output_holdoff();

        wait_drained();
        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire

FILE: filelist.f
+incdir+src
src/hpt4_pkg.sv
src/hpt4_mul_stage.sv
src/hpt4_acc_stage.sv
src/hpt4_sat_stage.sv
src/homogeneous_point_transform_4x4_core.sv
src/hpt4_checker.sv
test/tb_homogeneous_point_transform_4x4_core.sv
